// ===== rtl/fsp_pkg.sv =====
// ----------------------------------------------------------------------------
// Format specifier parser package
// Shared types, character codes, phase codes and the conversion classifier.
// ----------------------------------------------------------------------------
package fsp_pkg;

	// Parse phases.
	localparam logic [2:0] PH_IDLE      = 3'd0;
	localparam logic [2:0] PH_FLAGS     = 3'd1;
	localparam logic [2:0] PH_WIDTH     = 3'd2;
	localparam logic [2:0] PH_POSTWIDTH = 3'd3;
	localparam logic [2:0] PH_PREC      = 3'd4;
	localparam logic [2:0] PH_LENCONV   = 3'd5;
	localparam logic [2:0] PH_SAW_H     = 3'd6;
	localparam logic [2:0] PH_SAW_L     = 3'd7;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOT_SPEC = 2'd1;
	localparam logic [1:0] ST_UNKNOWN  = 2'd2;

	// Conversion classes.
	localparam logic [2:0] CL_INT   = 3'd0;
	localparam logic [2:0] CL_FLOAT = 3'd1;
	localparam logic [2:0] CL_PTR   = 3'd2;
	localparam logic [2:0] CL_PCT   = 3'd3;
	localparam logic [2:0] CL_NONE  = 3'd4;

	// Length modifier codes.
	localparam logic [3:0] LEN_NONE = 4'd0;
	localparam logic [3:0] LEN_HH   = 4'd1;
	localparam logic [3:0] LEN_H    = 4'd2;
	localparam logic [3:0] LEN_L    = 4'd3;
	localparam logic [3:0] LEN_LL   = 4'd4;
	localparam logic [3:0] LEN_BIGL = 4'd5;
	localparam logic [3:0] LEN_Z    = 4'd6;
	localparam logic [3:0] LEN_J    = 4'd7;
	localparam logic [3:0] LEN_T    = 4'd8;

	// Flag bit positions.
	localparam int FL_LEFT  = 0;
	localparam int FL_PLUS  = 1;
	localparam int FL_SPACE = 2;
	localparam int FL_ZERO  = 3;
	localparam int FL_ALT   = 4;

	// Characters of interest.
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_LOW_H   = 8'h68;
	localparam logic [7:0] CH_LOW_L   = 8'h6C;
	localparam logic [7:0] CH_UP_L    = 8'h4C;
	localparam logic [7:0] CH_LOW_Z   = 8'h7A;
	localparam logic [7:0] CH_LOW_J   = 8'h6A;
	localparam logic [7:0] CH_LOW_T   = 8'h74;

	// Control state of a spec in progress; numeric values travel separately.
	typedef struct packed {
		logic [2:0] phase;
		logic [4:0] flags;
		logic       width_star;
		logic       prec_present;
		logic       prec_star;
		logic [3:0] length;
	} spec_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  conversion_char;
		logic [2:0]  conversion_class;
		logic [4:0]  flag_bits;
		logic [15:0] field_width;
		logic        width_from_arg;
		logic [15:0] precision_value;
		logic        precision_given;
		logic        precision_from_arg;
		logic [3:0]  length_code;
	} res_t;

	function automatic logic [2:0] class_of(input logic [7:0] c);
		logic [2:0] cls;
		case (c) inside
			8'h64, 8'h69, 8'h75, 8'h78, 8'h58, 8'h6F, 8'h63: cls = CL_INT;
			8'h66, 8'h46, 8'h65, 8'h45, 8'h67, 8'h47, 8'h61, 8'h41: cls = CL_FLOAT;
			8'h70, 8'h73: cls = CL_PTR;
			CH_PERCENT, 8'h6E: cls = CL_PCT;
			default: cls = CL_NONE;
		endcase
		return cls;
	endfunction

endpackage

// ===== rtl/fsp_step.sv =====
// ----------------------------------------------------------------------------
// Format specifier parser step
// Next-state and result logic for one format character.
// ----------------------------------------------------------------------------
module fsp_step #(
	parameter int VAL_W = 16
) (
	input  logic [7:0]          c,
	input  fsp_pkg::spec_t      cur,
	input  logic [VAL_W-1:0]    cur_w,
	input  logic [VAL_W-1:0]    cur_p,
	output fsp_pkg::spec_t      nxt,
	output logic [VAL_W-1:0]    nxt_w,
	output logic [VAL_W-1:0]    nxt_p,
	output logic                emit,
	output fsp_pkg::res_t       res
);

	localparam logic [VAL_W+3:0] LIMIT = {4'b0, {VAL_W{1'b1}}};

	logic                digit;
	logic [VAL_W-1:0]    acc_src;
	logic [VAL_W+3:0]    acc_ext;
	logic [VAL_W+3:0]    prod;
	logic [VAL_W-1:0]    acc_sat;
	logic                lc_fin;
	logic [2:0]          lc_phase;
	logic [3:0]          lc_len;
	logic                go_aw;
	logic                go_lc;
	logic                fin;
	logic [3:0]          fin_len;
	logic [2:0]          fin_cls;

	assign digit = (c >= fsp_pkg::CH_ZERO) && (c <= fsp_pkg::CH_NINE);

	// One multiply-by-ten accumulator serves both width and precision.
	always_comb begin
		if (cur.phase == fsp_pkg::PH_PREC) begin
			acc_src = cur_p;
		end else if (cur.phase == fsp_pkg::PH_WIDTH) begin
			acc_src = cur_w;
		end else begin
			acc_src = '0;
		end
	end

	assign acc_ext = {4'b0, acc_src};
	assign prod    = (acc_ext << 3) + (acc_ext << 1) + (VAL_W+4)'(c[3:0]);
	assign acc_sat = (prod > LIMIT) ? {VAL_W{1'b1}} : prod[VAL_W-1:0];

	// Where a length modifier or the conversion character may stand.
	always_comb begin
		lc_fin   = 1'b0;
		lc_phase = cur.phase;
		lc_len   = cur.length;
		case (c)
			fsp_pkg::CH_LOW_H: lc_phase = fsp_pkg::PH_SAW_H;
			fsp_pkg::CH_LOW_L: lc_phase = fsp_pkg::PH_SAW_L;
			fsp_pkg::CH_UP_L: begin
				lc_len   = fsp_pkg::LEN_BIGL;
				lc_phase = fsp_pkg::PH_LENCONV;
			end
			fsp_pkg::CH_LOW_Z: begin
				lc_len   = fsp_pkg::LEN_Z;
				lc_phase = fsp_pkg::PH_LENCONV;
			end
			fsp_pkg::CH_LOW_J: begin
				lc_len   = fsp_pkg::LEN_J;
				lc_phase = fsp_pkg::PH_LENCONV;
			end
			fsp_pkg::CH_LOW_T: begin
				lc_len   = fsp_pkg::LEN_T;
				lc_phase = fsp_pkg::PH_LENCONV;
			end
			default: lc_fin = 1'b1;
		endcase
	end

	assign fin_cls = fsp_pkg::class_of(c);

	always_comb begin
		nxt     = cur;
		nxt_w   = cur_w;
		nxt_p   = cur_p;
		emit    = 1'b0;
		res     = '0;
		go_aw   = 1'b0;
		go_lc   = 1'b0;
		fin     = 1'b0;
		fin_len = cur.length;

		unique case (cur.phase)
			fsp_pkg::PH_IDLE: begin
				if (c == fsp_pkg::CH_PERCENT) begin
					nxt       = '0;
					nxt.phase = fsp_pkg::PH_FLAGS;
					nxt_w     = '0;
					nxt_p     = '0;
				end else begin
					emit                 = 1'b1;
					res.status           = fsp_pkg::ST_NOT_SPEC;
					res.conversion_char  = c;
					res.conversion_class = fsp_pkg::CL_NONE;
				end
			end
			fsp_pkg::PH_FLAGS: begin
				if (c == fsp_pkg::CH_MINUS) begin
					nxt.flags[fsp_pkg::FL_LEFT] = 1'b1;
				end else if (c == fsp_pkg::CH_PLUS) begin
					nxt.flags[fsp_pkg::FL_PLUS] = 1'b1;
				end else if (c == fsp_pkg::CH_SPACE) begin
					nxt.flags[fsp_pkg::FL_SPACE] = 1'b1;
				end else if (c == fsp_pkg::CH_ZERO) begin
					nxt.flags[fsp_pkg::FL_ZERO] = 1'b1;
				end else if (c == fsp_pkg::CH_HASH) begin
					nxt.flags[fsp_pkg::FL_ALT] = 1'b1;
				end else if (digit) begin
					nxt_w     = acc_sat;
					nxt.phase = fsp_pkg::PH_WIDTH;
				end else if (c == fsp_pkg::CH_STAR) begin
					nxt_w          = '0;
					nxt.width_star = 1'b1;
					nxt.phase      = fsp_pkg::PH_POSTWIDTH;
				end else begin
					go_aw = 1'b1;
				end
			end
			fsp_pkg::PH_WIDTH: begin
				if (digit) begin
					nxt_w = acc_sat;
				end else if (c == fsp_pkg::CH_STAR) begin
					nxt_w          = '0;
					nxt.width_star = 1'b1;
					nxt.phase      = fsp_pkg::PH_POSTWIDTH;
				end else begin
					go_aw = 1'b1;
				end
			end
			fsp_pkg::PH_POSTWIDTH: begin
				go_aw = 1'b1;
			end
			fsp_pkg::PH_PREC: begin
				if (digit) begin
					nxt_p = acc_sat;
				end else if (c == fsp_pkg::CH_STAR) begin
					nxt_p         = '0;
					nxt.prec_star = 1'b1;
					nxt.phase     = fsp_pkg::PH_LENCONV;
				end else begin
					go_lc = 1'b1;
				end
			end
			fsp_pkg::PH_LENCONV: begin
				// Once a modifier has been taken, the next character ends the spec.
				if (cur.length != fsp_pkg::LEN_NONE) begin
					fin = 1'b1;
				end else begin
					go_lc = 1'b1;
				end
			end
			fsp_pkg::PH_SAW_H: begin
				if (c == fsp_pkg::CH_LOW_H) begin
					nxt.length = fsp_pkg::LEN_HH;
					nxt.phase  = fsp_pkg::PH_LENCONV;
				end else begin
					fin     = 1'b1;
					fin_len = fsp_pkg::LEN_H;
				end
			end
			fsp_pkg::PH_SAW_L: begin
				if (c == fsp_pkg::CH_LOW_L) begin
					nxt.length = fsp_pkg::LEN_LL;
					nxt.phase  = fsp_pkg::PH_LENCONV;
				end else begin
					fin     = 1'b1;
					fin_len = fsp_pkg::LEN_L;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase

		if (go_aw) begin
			if (c == fsp_pkg::CH_DOT) begin
				nxt.prec_present = 1'b1;
				nxt_p            = '0;
				nxt.phase        = fsp_pkg::PH_PREC;
			end else begin
				go_lc = 1'b1;
			end
		end

		if (go_lc) begin
			if (lc_fin) begin
				fin = 1'b1;
			end else begin
				nxt.phase  = lc_phase;
				nxt.length = lc_len;
			end
		end

		if (fin) begin
			emit                   = 1'b1;
			res.status             = (fin_cls == fsp_pkg::CL_NONE) ?
			                         fsp_pkg::ST_UNKNOWN : fsp_pkg::ST_OK;
			res.conversion_char    = c;
			res.conversion_class   = fin_cls;
			res.flag_bits          = cur.flags;
			res.field_width        = 16'(cur_w);
			res.width_from_arg     = cur.width_star;
			res.precision_value    = 16'(cur_p);
			res.precision_given    = cur.prec_present;
			res.precision_from_arg = cur.prec_star;
			res.length_code        = fin_len;
			nxt                    = '0;
			nxt_w                  = '0;
			nxt_p                  = '0;
		end
	end

endmodule

// ===== rtl/format_specifier_parser.sv =====
// ----------------------------------------------------------------------------
// Format specifier parser
// Parses printf-style conversion specifications, one character per request.
// ----------------------------------------------------------------------------
// Characters arrive on the char channel (char_valid, char_stall, format_char).
// A '%' opens a specification; flags, width, precision and length modifier
// characters give no result, and the conversion character gives one result
// on the result channel. A character other than '%' outside a specification
// gives a not-a-spec result at once.
// Each request is held in an input register and parsed by one pass of logic
// into the result register, from which its result is offered; one character
// can be accepted every cycle while char_stall is low.
// While the receiver stalls a waiting result, characters that give no result
// still go through; one that would give a result waits in the input register
// and char_stall rises until the result register frees.
// Reset empties both registers and returns the parser to the idle phase.
// Width and precision saturate at 2^NUMBER_BITS-1, capped at 65535.
// ----------------------------------------------------------------------------
module format_specifier_parser #(
	parameter int NUMBER_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  format_char,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  status,
	output logic [7:0]  conversion_char,
	output logic [2:0]  conversion_class,
	output logic [4:0]  flag_bits,
	output logic [15:0] field_width,
	output logic        width_from_arg,
	output logic [15:0] precision_value,
	output logic        precision_given,
	output logic        precision_from_arg,
	output logic [3:0]  length_code
);

	localparam int VAL_W = (NUMBER_BITS < 16) ? NUMBER_BITS : 16;

	logic               valid_s1;
	logic [7:0]         char_s1;
	fsp_pkg::spec_t     spec_q;
	logic [VAL_W-1:0]   width_q;
	logic [VAL_W-1:0]   prec_q;
	fsp_pkg::spec_t     spec_nxt;
	logic [VAL_W-1:0]   width_nxt;
	logic [VAL_W-1:0]   prec_nxt;
	logic               emit;
	fsp_pkg::res_t      res;
	logic               out_valid_q;
	fsp_pkg::res_t      out_q;
	logic               advance;
	logic               accept;

	fsp_step #(
		.VAL_W (VAL_W)
	) u_step (
		.c     (char_s1),
		.cur   (spec_q),
		.cur_w (width_q),
		.cur_p (prec_q),
		.nxt   (spec_nxt),
		.nxt_w (width_nxt),
		.nxt_p (prec_nxt),
		.emit  (emit),
		.res   (res)
	);

	// A held character moves on unless it has a result with nowhere to go.
	assign advance    = valid_s1 && (!emit || !out_valid_q || !result_stall);
	assign char_stall = valid_s1 && !advance;
	assign accept     = char_valid && !char_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= format_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spec_q  <= '0;
			width_q <= '0;
			prec_q  <= '0;
		end else if (advance) begin
			spec_q  <= spec_nxt;
			width_q <= width_nxt;
			prec_q  <= prec_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= res;
		end
	end

	assign result_valid       = out_valid_q;
	assign status             = out_q.status;
	assign conversion_char    = out_q.conversion_char;
	assign conversion_class   = out_q.conversion_class;
	assign flag_bits          = out_q.flag_bits;
	assign field_width        = out_q.field_width;
	assign width_from_arg     = out_q.width_from_arg;
	assign precision_value    = out_q.precision_value;
	assign precision_given    = out_q.precision_given;
	assign precision_from_arg = out_q.precision_from_arg;
	assign length_code        = out_q.length_code;

endmodule

// ===== rtl/fsp_checker.sv =====
// ----------------------------------------------------------------------------
// Format specifier parser checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module fsp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_stall,
	input logic [1:0]  status,
	input logic [7:0]  conversion_char,
	input logic [2:0]  conversion_class,
	input logic [4:0]  flag_bits,
	input logic [15:0] field_width,
	input logic        width_from_arg
);

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result request dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(status) && $stable(conversion_char))
		else $error("stalled result request changed");

	// A character outside a specification carries nothing but itself.
	a_not_spec_bare: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == fsp_pkg::ST_NOT_SPEC |->
			conversion_class == fsp_pkg::CL_NONE && flag_bits == 5'd0 &&
			field_width == 16'd0)
		else $error("not-a-spec result carries spec fields");

	a_status_class: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
			((status == fsp_pkg::ST_OK) == (conversion_class != fsp_pkg::CL_NONE)))
		else $error("status disagrees with conversion class");

	a_star_width_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && width_from_arg |-> field_width == 16'd0)
		else $error("width taken from argument but digits reported");

endmodule

bind format_specifier_parser fsp_checker u_fsp_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.result_valid     (result_valid),
	.result_stall     (result_stall),
	.status           (status),
	.conversion_char  (conversion_char),
	.conversion_class (conversion_class),
	.flag_bits        (flag_bits),
	.field_width      (field_width),
	.width_from_arg   (width_from_arg)
);
